// File: rtl/rnea_pkg.sv
// Shared types, constants and fixed-point helpers of the regularizer block.
`default_nettype none
package rnea_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 176;
  localparam int OUT_W     = 144;
  localparam int ADDR_W    = 5;
  localparam int NUM_W     = 48;
  localparam int DEN_W     = 35;
  localparam int QUO_W     = 31;

  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_WEIGHT = 3'd1;
  localparam logic [2:0] REG_LKNEE  = 3'd2;
  localparam logic [2:0] REG_UKNEE  = 3'd3;
  localparam logic [2:0] REG_GAIN   = 3'd4;
  localparam logic [2:0] REG_EPS    = 3'd5;

  localparam logic [2:0] MODE_PCA   = 3'd0;
  localparam logic [2:0] MODE_L1    = 3'd1;
  localparam logic [2:0] MODE_L2    = 3'd2;
  localparam logic [2:0] MODE_MIXED = 3'd3;
  localparam logic [2:0] MODE_TIKH  = 3'd4;

  localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] S32_MIN = -64'sh0000_0000_8000_0000;

  typedef struct packed {
    logic [2:0]  mode;
    logic [30:0] weight;
    logic [30:0] lower_knee;
    logic [31:0] upper_knee;
    logic [31:0] slope_gain;
    logic [15:0] abs_offset;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_PCA_Q, OP_PCA_K, OP_QK, OP_QT, OP_L1_DIV, OP_L1_E,
    OP_M_LU, OP_M_LUU, OP_M_CU, OP_M_WL, OP_M_ADIV, OP_M_WA,
    OP_M_LX, OP_M_LXX, OP_M_CX, OP_M_WG, OP_M_WE, OP_M_EM, OP_END
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ISSUE = 5'b00010,
    ST_DIVW  = 5'b00100,
    ST_POST  = 5'b01000,
    ST_ACC   = 5'b10000
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) r = 32'sh7FFF_FFFF;
    else if (v < S32_MIN) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [63:0] fshr(input logic signed [63:0] v);
    return v >>> FRAC_BITS;
  endfunction

  function automatic logic signed [63:0] ext64(input logic signed [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [63:0] s;
    logic signed [63:0] r;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63])
      r = a[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    else
      r = s;
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/rnea_cfg.sv
// APB register file holding the penalty configuration.
`default_nettype none
module rnea_cfg import rnea_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic      [31:0]       cfg_prdata,
  output logic                   cfg_pready,
  output cfg_t                   cfg_o
);

  cfg_t        cfg_r;
  logic [2:0]  idx;

  assign idx        = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;
  assign cfg_o      = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode       <= MODE_L2;
      cfg_r.weight     <= 31'd65536;
      cfg_r.lower_knee <= 31'd65536;
      cfg_r.upper_knee <= 32'd131072;
      cfg_r.slope_gain <= 32'd65536;
      cfg_r.abs_offset <= 16'd1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (idx)
        REG_MODE:   cfg_r.mode       <= cfg_pwdata[2:0];
        REG_WEIGHT: cfg_r.weight     <= cfg_pwdata[30:0];
        REG_LKNEE:  cfg_r.lower_knee <= cfg_pwdata[30:0];
        REG_UKNEE:  cfg_r.upper_knee <= cfg_pwdata;
        REG_GAIN:   cfg_r.slope_gain <= cfg_pwdata;
        REG_EPS:    cfg_r.abs_offset <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE:   cfg_prdata = {29'b0, cfg_r.mode};
      REG_WEIGHT: cfg_prdata = {1'b0, cfg_r.weight};
      REG_LKNEE:  cfg_prdata = {1'b0, cfg_r.lower_knee};
      REG_UKNEE:  cfg_prdata = cfg_r.upper_knee;
      REG_GAIN:   cfg_prdata = cfg_r.slope_gain;
      REG_EPS:    cfg_prdata = {16'b0, cfg_r.abs_offset};
      default:    cfg_prdata = 32'b0;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/rnea_div.sv
// Radix-2 restoring divider with saturation of the quotient to 31 bits.
`default_nettype none
module rnea_div import rnea_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic      [QUO_W-1:0] quo_o
);

  logic             busy_r, done_r;
  logic [4:0]       cnt_r;
  logic [DEN_W-1:0] rem_r, den_r;
  logic [31:0]      num_r, quo_r;
  logic             ovf, ge;
  logic [DEN_W:0]   trial, diff;

  // quotient of 2^31 or more (or zero divisor) saturates at once
  assign ovf   = (den_i == '0) || ({18'b0, num_i[NUM_W-1:31]} >= den_i);
  assign trial = {rem_r, num_r[31]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  assign done_o = done_r;
  assign quo_o  = quo_r[QUO_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start_i) begin
      busy_r <= !ovf;
      done_r <= ovf;
    end else if (busy_r && cnt_r == 5'd0) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      den_r <= den_i;
      rem_r <= {19'b0, num_i[NUM_W-1:32]};
      num_r <= num_i[31:0];
      cnt_r <= 5'd31;
      quo_r <= ovf ? 32'h7FFF_FFFF : 32'b0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_r <= {quo_r[30:0], ge};
      num_r <= {num_r[30:0], 1'b0};
      cnt_r <= cnt_r - 5'd1;
    end
  end

endmodule
`default_nettype wire

// File: rtl/regularizer_normal_eq_accumulate.sv
// Top level: item sequencer around one shared multiplier and the divider.
//
// Adds a regularizer term to one normal-equation diagonal and gradient entry
// per request on the in_ stream; the result leaves on the out_ stream with
// the element index passed through. The penalty error adds up in a Q32.32
// accumulator; its total shows in the result of the element marked tlast,
// and the accumulator then clears.
// Configuration goes through the cfg_ APB port; the user must write it only
// while idle, as the block itself does not enforce this. Each request is
// worked by a sequencer that runs one multiply (product, then post step) or
// one divide (issue, wait for the divider, then post step; the divider ends
// at once when the quotient saturates) at a time. In pca mode two divides
// run; mixed at zero weight and unused modes go straight to the result. The
// result becomes valid in the same cycle that the next request can be taken.
// in_tready is high only in the idle state; a finished result sits in the
// output register while the next request is already taken in, and the
// sequencer waits at its last step until that register is free.
// Reset restores register defaults and clears the accumulator and the
// output valid.
`default_nettype none
module regularizer_normal_eq_accumulate import rnea_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // x_value, prior_value, sigma_value, cur_diag, cur_grad, elem_index, pad
  input  wire logic [IN_W-1:0]   in_tdata,
  input  wire logic              in_tlast,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // new_diag, new_grad, out_index, error_total, pad
  output logic      [OUT_W-1:0]  out_tdata,
  output logic                   out_tlast,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic      [31:0]       cfg_prdata,
  output logic                   cfg_pready
);

  cfg_t cfg;

  rnea_cfg u_cfg (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg_pready, .cfg_o(cfg)
  );

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  logic signed [31:0] x_r, diag_r, grad_r;
  logic        [30:0] sigma_r;
  logic        [9:0]  idx_r;
  logic               last_r;
  logic signed [31:0] k_r, k_nxt, v_r, t_r, t_nxt;
  logic signed [31:0] dk_r, dk_nxt, dg_r, dg_nxt;
  logic signed [63:0] de_r, de_nxt, p_r, q_r, q_nxt, acc_r;
  logic signed [31:0] wl_r, wl_nxt, c_r, c_nxt, d_r, d_nxt;
  logic signed [31:0] lx_r, lx_nxt, g_r, g_nxt;
  logic        [30:0] a_r, a_nxt;
  logic signed [47:0] lu_r, lu_nxt;
  logic signed [49:0] dacc_r, dacc_nxt;

  logic               out_valid_r;
  logic [OUT_W-1:0]   out_data_r;
  logic               out_last_r;

  logic               accept, is_div, div_start, div_done;
  logic [NUM_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic [QUO_W-1:0]   div_quo;
  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;

  logic signed [31:0] in_x, in_prior, ukn, gain, wsg;
  logic        [31:0] x_abs;
  logic        [32:0] axe;
  logic signed [33:0] xeb;
  logic signed [32:0] xs33, ls33, tik_v;
  logic signed [63:0] pf, acc_sum, c_wide;
  logic signed [32:0] nd_sum, ng_sum;
  logic signed [31:0] lu_s, qe_s, xeb_s;
  op_t                op_first;
  logic signed [31:0] k_first, v_first;

  assign in_x     = in_tdata[31:0];
  assign in_prior = in_tdata[63:32];
  assign ukn      = cfg.upper_knee;
  assign gain     = cfg.slope_gain;
  assign wsg      = {1'b0, cfg.weight};

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  assign x_abs = x_r[31] ? (~x_r + 32'd1) : x_r;
  assign axe   = {1'b0, x_abs} + {17'b0, cfg.abs_offset};
  assign xeb   = {{2{x_r[31]}}, x_r} + {18'b0, cfg.abs_offset}
               - {4'b0, cfg.lower_knee[30:1]};
  assign xs33  = {x_r[31], x_r};
  assign ls33  = {2'b0, cfg.lower_knee};
  assign tik_v = {in_x[31], in_x} - {in_prior[31], in_prior};
  assign pf    = fshr(p_r);
  assign lu_s  = sat32({{16{lu_r[47]}}, lu_r});
  assign qe_s  = sat32(fshr(q_r));
  assign xeb_s = sat32({{30{xeb[33]}}, xeb});

  // first step and quadratic operands at accept
  always_comb begin
    k_first = wsg;
    v_first = in_x;
    unique case (cfg.mode)
      MODE_PCA:   op_first = OP_PCA_Q;
      MODE_L1:    op_first = OP_L1_DIV;
      MODE_L2:    op_first = OP_QK;
      MODE_MIXED: op_first = (cfg.weight != '0) ? OP_M_LU : OP_END;
      MODE_TIKH: begin
        op_first = OP_QK;
        v_first  = sat32({{31{tik_v[32]}}, tik_v});
      end
      default:    op_first = OP_END;
    endcase
  end

  assign is_div = (op_r == OP_PCA_Q) || (op_r == OP_PCA_K) ||
                  (op_r == OP_L1_DIV) || (op_r == OP_M_ADIV);
  assign div_start = (state_r == ST_ISSUE) && is_div;

  always_comb begin
    div_num = {1'b0, cfg.weight, 16'b0};
    div_den = {4'b0, sigma_r};
    unique case (op_r)
      OP_PCA_K:  div_num = {1'b0, k_r[30:0], 16'b0};
      OP_L1_DIV: div_den = {axe, 2'b00};
      OP_M_ADIV: begin
        div_num = {16'b0, 1'b1, 31'b0};
        div_den = {4'b0, cfg.lower_knee};
      end
      default: ;
    endcase
  end

  rnea_div u_div (
    .clk, .rst_n, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  // shared multiplier operand select
  always_comb begin
    ma = {{2{k_r[31]}}, k_r};
    mb = {{2{v_r[31]}}, v_r};
    unique case (op_r)
      OP_QT:    ma = {{2{t_r[31]}}, t_r};
      OP_L1_E:  begin ma = {2'b0, wsg}; mb = {1'b0, axe}; end
      OP_M_LU:  begin ma = {{2{gain[31]}}, gain}; mb = {{2{ukn[31]}}, ukn}; end
      OP_M_LUU: begin
        ma = {{2{lu_s[31]}}, lu_s};
        mb = {{2{ukn[31]}}, ukn};
      end
      OP_M_CU:  begin ma = {{2{c_r[31]}}, c_r}; mb = {{2{ukn[31]}}, ukn}; end
      OP_M_WL:  begin ma = {2'b0, wsg}; mb = {{2{gain[31]}}, gain}; end
      OP_M_WA:  begin ma = {2'b0, wsg}; mb = {3'b0, a_r}; end
      OP_M_LX:  begin ma = {{2{gain[31]}}, gain}; mb = {{2{x_r[31]}}, x_r}; end
      OP_M_LXX: begin ma = {{2{lx_r[31]}}, lx_r}; mb = {{2{x_r[31]}}, x_r}; end
      OP_M_CX:  begin ma = {{2{c_r[31]}}, c_r}; mb = {{2{x_r[31]}}, x_r}; end
      OP_M_WG:  begin ma = {2'b0, wsg}; mb = {{2{g_r[31]}}, g_r}; end
      OP_M_WE:  begin
        ma = {2'b0, wsg};
        mb = {{2{qe_s[31]}}, qe_s};
      end
      OP_M_EM:  begin
        ma = {2'b0, wsg};
        mb = {{2{xeb_s[31]}}, xeb_s};
      end
      default: ;
    endcase
  end

  assign prod = ma * mb;

  assign c_wide = 64'sd65536 - ({{16{lu_r[47]}}, lu_r} <<< 1);

  // post step: fold the product or quotient into the working registers
  always_comb begin
    op_nxt   = op_r;
    k_nxt    = k_r;
    t_nxt    = t_r;
    dk_nxt   = dk_r;
    dg_nxt   = dg_r;
    de_nxt   = de_r;
    q_nxt    = q_r;
    wl_nxt   = wl_r;
    c_nxt    = c_r;
    d_nxt    = d_r;
    lx_nxt   = lx_r;
    g_nxt    = g_r;
    a_nxt    = a_r;
    lu_nxt   = lu_r;
    dacc_nxt = dacc_r;
    unique case (op_r)
      OP_PCA_Q: begin k_nxt = {1'b0, div_quo}; op_nxt = OP_PCA_K; end
      OP_PCA_K: begin k_nxt = {1'b0, div_quo}; op_nxt = OP_QK; end
      OP_QK: begin
        t_nxt  = sat32(pf);
        dk_nxt = k_r;
        dg_nxt = sat32(pf);
        op_nxt = OP_QT;
      end
      OP_QT: begin de_nxt = p_r; op_nxt = OP_END; end
      OP_L1_DIV: begin
        dk_nxt = {1'b0, div_quo};
        dg_nxt = x_r[31] ? -{2'b0, cfg.weight[30:1]} : {2'b0, cfg.weight[30:1]};
        op_nxt = (cfg.mode == MODE_L1) ? OP_L1_E : OP_M_EM;
      end
      OP_L1_E, OP_M_EM: begin de_nxt = p_r; op_nxt = OP_END; end
      OP_M_LU: begin
        lu_nxt   = pf[47:0];
        op_nxt   = OP_M_LUU;
        dacc_nxt = {{18{ukn[31]}}, ukn} - {20'b0, cfg.lower_knee[30:1]};
      end
      OP_M_LUU: begin
        c_nxt    = sat32(c_wide);
        dacc_nxt = dacc_r - pf[49:0];
        op_nxt   = OP_M_CU;
      end
      OP_M_CU: begin
        d_nxt  = sat32({{14{dacc_r[49]}}, dacc_r} - pf);
        op_nxt = OP_M_WL;
      end
      OP_M_WL: begin
        wl_nxt = sat32(pf);
        if (x_r[31]) begin
          k_nxt  = sat32(pf);
          op_nxt = OP_QK;
        end else if (xs33 < ls33) begin
          op_nxt = OP_M_ADIV;
        end else if (x_r > ukn) begin
          op_nxt = OP_M_LX;
        end else begin
          op_nxt = OP_L1_DIV;
        end
      end
      OP_M_ADIV: begin a_nxt = div_quo; op_nxt = OP_M_WA; end
      OP_M_WA: begin k_nxt = sat32(pf); op_nxt = OP_QK; end
      OP_M_LX: begin
        lx_nxt = sat32(pf);
        g_nxt  = sat32(ext64(sat32(pf)) + ext64({c_r[31], c_r[31:1]}));
        op_nxt = OP_M_LXX;
      end
      OP_M_LXX: begin q_nxt = p_r; op_nxt = OP_M_CX; end
      OP_M_CX: begin q_nxt = sadd64(q_r, p_r); op_nxt = OP_M_WG; end
      OP_M_WG: begin
        dg_nxt = sat32(pf);
        q_nxt  = sadd64(q_r, {{16{d_r[31]}}, d_r, 16'b0});
        op_nxt = OP_M_WE;
      end
      OP_M_WE: begin de_nxt = p_r; dk_nxt = wl_r; op_nxt = OP_END; end
      default: op_nxt = OP_END;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept) state_nxt = (op_first == OP_END) ? ST_ACC : ST_ISSUE;
      ST_ISSUE: state_nxt = is_div ? ST_DIVW : ST_POST;
      ST_DIVW:  if (div_done) state_nxt = ST_POST;
      ST_POST:  state_nxt = (op_nxt == OP_END) ? ST_ACC : ST_ISSUE;
      ST_ACC:   if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  assign acc_sum = sadd64(acc_r, de_r);
  assign nd_sum  = {diag_r[31], diag_r} + {dk_r[31], dk_r};
  assign ng_sum  = {grad_r[31], grad_r} + {dg_r[31], dg_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_ACC && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
        acc_r       <= last_r ? 64'sd0 : acc_sum;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r     <= in_x;
      sigma_r <= in_tdata[94:64];
      diag_r  <= in_tdata[126:95];
      grad_r  <= in_tdata[158:127];
      idx_r   <= in_tdata[168:159];
      last_r  <= in_tlast;
      op_r    <= op_first;
      k_r     <= k_first;
      v_r     <= v_first;
      dk_r    <= '0;
      dg_r    <= '0;
      de_r    <= '0;
    end else if (state_r == ST_POST) begin
      op_r <= op_nxt;
      k_r  <= k_nxt;
      t_r  <= t_nxt;
      dk_r <= dk_nxt;
      dg_r <= dg_nxt;
      de_r <= de_nxt;
      q_r  <= q_nxt;
      wl_r <= wl_nxt;
      c_r  <= c_nxt;
      d_r  <= d_nxt;
      lx_r <= lx_nxt;
      g_r  <= g_nxt;
      a_r  <= a_nxt;
      lu_r <= lu_nxt;
      dacc_r <= dacc_nxt;
    end
    if (state_r == ST_ISSUE && !is_div) p_r <= prod[63:0];
    if (state_r == ST_ACC && (!out_valid_r || out_tready)) begin
      out_data_r <= {6'b0, last_r ? acc_sum : 64'sd0, idx_r,
                     sat32({{31{ng_sum[32]}}, ng_sum}),
                     sat32({{31{nd_sum[32]}}, nd_sum})};
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

// File: rtl/rnea_chk.sv
// Port-level checker of the regularizer block, bound to the top level.
`default_nettype none
module rnea_chk import rnea_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_tvalid,
  input wire logic             in_tready,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [OUT_W-1:0] out_tdata,
  input wire logic             out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while sequencer busy");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[137:74] == 64'b0)
    else $error("error total shown on non-final result");

endmodule

bind regularizer_normal_eq_accumulate rnea_chk u_rnea_chk (.*);
`default_nettype wire
